[hdl/nbcmc_pkg.sv]
// Shared types and status codes for the non-blocking cache miss controller.
`timescale 1ns / 1ps
package nbcmc_pkg;
    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_WBUF    = 3'd1,
        ST_NEWLOAD = 3'd2,
        ST_MERGED  = 3'd3,
        ST_REJECT  = 3'd4,
        ST_WROTE   = 3'd5,
        ST_LOADED  = 3'd6,
        ST_IDLE    = 3'd7
    } t_status;

    // search request from sequencer to the scan unit, and its answer
    typedef struct packed {
        logic start;
        logic which;   // 0 write-back queue, 1 load queue
    } t_scan_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } t_scan_rsp;
endpackage

[hdl/nonblocking_cache_miss_controller.sv]
// Top level: tag store, two queues and the access/dispatch sequencer.
// A hit passes S_LOOK and S_OUT, a dispatch S_LOOK, S_DISP and S_OUT, before result valid.
// A miss scans the write-back queue, then the load queue if the block is not in the
// write-back queue, one entry per cycle. One item at a time; input ready
// returns the cycle after the result transfer. Synchronous active-low reset
// clears valid/dirty bits, queue pointers and counts; threshold resets to 6.
`timescale 1ns / 1ps
module nonblocking_cache_miss_controller #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int NUM_SETS     = 64,
    parameter int OFFSET_BITS  = 5,
    parameter int THREADS      = 2,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [3:0]              i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_command,
    input  logic [ADDRESS_BITS-1:0] i_address,
    input  logic                    i_is_write,
    input  logic [((THREADS > 1) ? $clog2(THREADS) : 1)-1:0] i_thread_id,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [2:0]              o_status,
    output logic                    o_victim_flushed,
    output logic [THREADS-1:0]      o_wake_mask,
    output logic [ADDRESS_BITS-OFFSET_BITS-1:0] o_memory_block,
    output logic [$clog2(QUEUE_DEPTH):0] o_write_count,
    output logic [$clog2(QUEUE_DEPTH):0] o_load_count
);
    import nbcmc_pkg::*;
    localparam int BW = ADDRESS_BITS - OFFSET_BITS;
    localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SB = $clog2(NUM_SETS);
    localparam int TW = BW - SB;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = PW + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOOK  = 7'b0000010,
        S_WBS   = 7'b0000100,
        S_PDS   = 7'b0001000,
        S_DECIDE= 7'b0010000,
        S_DISP  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_thr;
    logic [NUM_SETS-1:0] r_vld, r_drt;
    logic [TW-1:0] tag_mem [NUM_SETS];
    logic [BW-1:0] wb_mem [QUEUE_DEPTH];
    logic [BW-1:0] pd_mem [QUEUE_DEPTH];
    logic [THREADS-1:0] pw_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wh, r_wt, r_ph, r_pt;
    logic [CW-1:0] r_wc, r_pc;

    logic          r_cmd, r_wr;
    logic [BW-1:0] r_blk;
    logic [THREADS-1:0] r_tbit;
    logic [TW-1:0] r_tagrd;
    logic          r_inwb, r_pfound;
    logic [PW-1:0] r_pidx;
    logic [BW-1:0] r_wbrd, r_pdrd;
    logic [THREADS-1:0] r_pwrd;

    logic          r_ovalid;
    logic [2:0]    r_ost;
    logic          r_ofl;
    logic [THREADS-1:0] r_owk;
    logic [BW-1:0] r_oblk;

    t_scan_req scan_req;
    t_scan_rsp scan_rsp;
    logic [PW-1:0] scan_ptr;

    logic [SW-1:0] set_w;
    logic [SW-1:0] set_in;
    logic [TW-1:0] tag_w;
    assign set_w  = (NUM_SETS > 1) ? SW'(r_blk) : '0;
    assign set_in = (NUM_SETS > 1) ? SW'(i_address >> OFFSET_BITS) : '0;
    assign tag_w  = TW'(r_blk >> SB);

    nbcmc_scan #(.QD(QUEUE_DEPTH), .BW(BW)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(scan_req),
        .i_tail(scan_req.which ? r_pt : r_wt),
        .i_count(scan_req.which ? r_pc : r_wc),
        .i_key(r_blk),
        .i_entry((r_state == S_PDS) ? pd_mem[scan_ptr] : wb_mem[scan_ptr]),
        .o_ptr(scan_ptr), .o_rsp(scan_rsp)
    );

    logic hit, victim, needload, reject;
    assign hit      = r_vld[set_w] && (r_tagrd == tag_w);
    assign victim   = r_vld[set_w] && r_drt[set_w];
    assign needload = !r_inwb && !r_pfound;
    assign reject   = (victim && r_wc >= CW'(QUEUE_DEPTH)) ||
                      (needload && r_pc >= CW'(QUEUE_DEPTH));

    assign o_ready     = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    logic take;
    assign take = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        scan_req = '{start: 1'b0, which: 1'b0};
        case (r_state)
            S_IDLE:   if (take) n_state = S_LOOK;
            S_LOOK: begin
                if (r_cmd) n_state = S_DISP;
                else if (hit) n_state = S_OUT;
                else begin
                    scan_req = '{start: 1'b1, which: 1'b0};
                    n_state = S_WBS;
                end
            end
            S_WBS: if (scan_rsp.done) begin
                if (scan_rsp.found) n_state = S_DECIDE;
                else begin
                    scan_req = '{start: 1'b1, which: 1'b1};
                    n_state = S_PDS;
                end
            end
            S_PDS:    if (scan_rsp.done) n_state = S_DECIDE;
            S_DECIDE: n_state = S_OUT;
            S_DISP:   n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    logic wfirst;
    assign wfirst = (32'(r_wc) > 32'(r_thr)) || (r_pc == '0);

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd  <= i_command;
            r_wr   <= i_is_write;
            r_blk  <= BW'(i_address >> OFFSET_BITS);
            r_tbit <= (32'(i_thread_id) < THREADS) ? THREADS'(1) << i_thread_id : '0;
        end
        // read the new item's set on its transfer so the tag is ready for the lookup
        r_tagrd <= tag_mem[take ? set_in : set_w];
        r_wbrd  <= wb_mem[r_wh];
        r_pdrd  <= pd_mem[r_ph];
        r_pwrd  <= pw_mem[r_ph];
        if (r_state == S_WBS && scan_rsp.done) begin
            r_inwb <= scan_rsp.found; r_pfound <= 1'b0;
        end
        if (r_state == S_PDS && scan_rsp.done) begin
            r_pfound <= scan_rsp.found; r_pidx <= scan_ptr;
        end
        if (r_state == S_DECIDE && !reject) begin
            if (victim) wb_mem[r_wt] <= BW'({r_tagrd, set_w}) ;
            if (r_inwb) tag_mem[set_w] <= tag_w;
            else if (r_pfound) pw_mem[r_pidx] <= pw_mem[r_pidx] | r_tbit;
            else begin
                pd_mem[r_pt] <= r_blk; pw_mem[r_pt] <= r_tbit;
            end
        end
        if (r_state == S_DISP && !wfirst)
            tag_mem[(NUM_SETS > 1) ? SW'(r_pdrd) : '0] <= TW'(r_pdrd >> SB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_thr <= 4'd6; r_vld <= '0; r_drt <= '0;
            r_wh <= '0; r_wt <= '0; r_ph <= '0; r_pt <= '0;
            r_wc <= '0; r_pc <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_thr <= i_cfg_data;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == S_LOOK && !r_cmd && hit) begin
                if (r_wr) r_drt[set_w] <= 1'b1;
                r_ost <= ST_HIT; r_ofl <= 1'b0; r_owk <= '0; r_oblk <= '0;
            end
            if (r_state == S_DECIDE) begin
                r_ofl <= 1'b0; r_owk <= '0; r_oblk <= r_blk;
                if (reject) begin
                    r_ost <= ST_REJECT; r_oblk <= '0;
                end else begin
                    if (victim) begin
                        r_vld[set_w] <= 1'b0; r_drt[set_w] <= 1'b0;
                        r_wt <= (r_wt == PW'(QUEUE_DEPTH-1)) ? '0 : r_wt + 1'b1;
                        r_wc <= r_wc + 1'b1; r_ofl <= 1'b1;
                    end
                    if (r_inwb) begin
                        r_vld[set_w] <= 1'b1; r_drt[set_w] <= 1'b0;
                        r_owk <= r_tbit; r_ost <= ST_WBUF;
                    end else if (r_pfound) r_ost <= ST_MERGED;
                    else begin
                        r_pt <= (r_pt == PW'(QUEUE_DEPTH-1)) ? '0 : r_pt + 1'b1;
                        r_pc <= r_pc + 1'b1; r_ost <= ST_NEWLOAD;
                    end
                end
            end
            if (r_state == S_DISP) begin
                r_ofl <= 1'b0; r_owk <= '0; r_oblk <= '0; r_ost <= ST_IDLE;
                if (wfirst) begin
                    if (r_wc != '0) begin
                        r_oblk <= r_wbrd; r_ost <= ST_WROTE;
                        r_wh <= (r_wh == PW'(QUEUE_DEPTH-1)) ? '0 : r_wh + 1'b1;
                        r_wc <= r_wc - 1'b1;
                    end
                end else begin
                    r_oblk <= r_pdrd; r_owk <= r_pwrd; r_ost <= ST_LOADED;
                    r_ph <= (r_ph == PW'(QUEUE_DEPTH-1)) ? '0 : r_ph + 1'b1;
                    r_pc <= r_pc - 1'b1;
                    r_vld[(NUM_SETS > 1) ? SW'(r_pdrd) : '0] <= 1'b1;
                    r_drt[(NUM_SETS > 1) ? SW'(r_pdrd) : '0] <= 1'b0;
                end
            end
            if (r_state == S_OUT) r_ovalid <= 1'b1;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ost;
    assign o_victim_flushed = r_ofl;
    assign o_wake_mask      = r_owk;
    assign o_memory_block   = r_oblk;
    assign o_write_count    = r_wc;
    assign o_load_count     = r_pc;

    a_wc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc <= CW'(QUEUE_DEPTH)) else $error("write queue overflow");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= CW'(QUEUE_DEPTH)) else $error("load queue overflow");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
endmodule

[hdl/nbcmc_scan.sv]
// Shared compare unit: walks one queue newest to oldest, one entry per cycle.
`timescale 1ns / 1ps
module nbcmc_scan #(
    parameter int QD = 8,
    parameter int BW = 27
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nbcmc_pkg::t_scan_req  i_req,
    input  logic [$clog2(QD)-1:0] i_tail,
    input  logic [$clog2(QD):0]   i_count,
    input  logic [BW-1:0]         i_key,
    input  logic [BW-1:0]         i_entry,
    output logic [$clog2(QD)-1:0] o_ptr,
    output nbcmc_pkg::t_scan_rsp  o_rsp
);
    import nbcmc_pkg::*;
    localparam int PW = $clog2(QD);

    logic [PW-1:0] r_ptr, n_ptr;
    logic [PW:0]   r_left, n_left;
    logic          r_busy, n_busy, r_done, n_done, r_found, n_found;

    function automatic logic [PW-1:0] prev(input logic [PW-1:0] p);
        prev = (p == '0) ? PW'(QD - 1) : p - 1'b1;
    endfunction

    always_comb begin
        n_ptr = r_ptr; n_left = r_left; n_busy = r_busy;
        n_done = 1'b0; n_found = r_found;
        if (i_req.start) begin
            n_ptr = prev(i_tail); n_left = i_count; n_found = 1'b0;
            n_busy = (i_count != '0);
            n_done = (i_count == '0);
        end else if (r_busy) begin
            if (i_entry == i_key) begin
                n_found = 1'b1; n_busy = 1'b0; n_done = 1'b1;
            end else if (r_left == (PW+1)'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end else begin
                n_ptr = prev(r_ptr); n_left = r_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_found <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_found <= n_found;
        end
        r_ptr <= n_ptr; r_left <= n_left;
    end

    assign o_ptr = r_ptr;
    assign o_rsp = '{busy: r_busy, done: r_done, found: r_found};

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !i_req.start) |=> !r_done) else $error("scan done held");
    a_busy_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done) else $error("scan busy and done");
    a_left_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_left != '0) else $error("scan count underflow");
endmodule

[tb/nbcmc_scoreboard.sv]
// Checker for the miss controller: predicts each result and compares it at the output.
`timescale 1ns / 1ps
module nbcmc_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_command,
    input  logic [31:0] i_address,
    input  logic        i_is_write,
    input  logic        i_thread_id,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic        i_victim_flushed,
    input  logic [1:0]  i_wake_mask,
    input  logic [26:0] i_memory_block,
    input  logic [3:0]  i_write_count,
    input  logic [3:0]  i_load_count,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_items,
    output logic [7:0]  o_status_seen
);
    import nbcmc_pkg::*;
    localparam int DEPTH = 8;
    localparam int SETS  = 64;

    typedef struct packed {
        t_status     status;
        logic        flushed;
        logic [1:0]  wake;
        logic [26:0] blk;
        logic [3:0]  wcount;
        logic [3:0]  lcount;
    } t_miss_result;

    logic        line_valid [SETS];
    logic        line_dirty [SETS];
    logic [20:0] line_tag   [SETS];
    logic [26:0] wb_blocks  [DEPTH];
    logic [26:0] ld_blocks  [DEPTH];
    logic [1:0]  ld_waiters [DEPTH];
    int          wb_head, wb_tail, wb_count;
    int          ld_head, ld_tail, ld_count;
    logic [3:0]  dispatch_level;

    t_miss_result expected_results[$];

    function automatic t_miss_result process_request(logic cmd, logic [31:0] addr,
                                                     logic wr, logic tid);
        t_miss_result r;
        logic [26:0]  blk;
        int           set;
        logic [20:0]  tag;
        logic         victim, in_wb, need_load;
        int           pidx, p;
        r = '{status: ST_IDLE, default: '0};
        if (!cmd) begin
            blk = addr[31:5];
            set = blk[5:0];
            tag = blk[26:6];
            if (line_valid[set] && line_tag[set] == tag) begin
                if (wr) line_dirty[set] = 1'b1;
                r.status = ST_HIT;
            end else begin
                victim = line_valid[set] && line_dirty[set];
                in_wb = 1'b0;
                pidx = -1;
                // search newest first
                for (int n = 0; n < wb_count; n++) begin
                    p = (wb_tail - 1 - n + 2 * DEPTH) % DEPTH;
                    if (wb_blocks[p] == blk) in_wb = 1'b1;
                end
                if (!in_wb) begin
                    for (int n = ld_count - 1; n >= 0; n--) begin
                        p = (ld_tail - 1 - n + 2 * DEPTH) % DEPTH;
                        if (ld_blocks[p] == blk) pidx = p;
                    end
                end
                need_load = !in_wb && pidx < 0;
                if ((victim && wb_count >= DEPTH) || (need_load && ld_count >= DEPTH)) begin
                    r.status = ST_REJECT;
                end else begin
                    if (victim) begin
                        line_valid[set] = 1'b0;
                        line_dirty[set] = 1'b0;
                        wb_blocks[wb_tail] = {line_tag[set], 6'(set)};
                        wb_tail = (wb_tail + 1) % DEPTH;
                        wb_count++;
                        r.flushed = 1'b1;
                    end
                    r.blk = blk;
                    if (in_wb) begin
                        line_valid[set] = 1'b1;
                        line_dirty[set] = 1'b0;
                        line_tag[set] = tag;
                        r.wake = 2'b01 << tid;
                        r.status = ST_WBUF;
                    end else if (pidx >= 0) begin
                        ld_waiters[pidx] |= 2'b01 << tid;
                        r.status = ST_MERGED;
                    end else begin
                        ld_blocks[ld_tail] = blk;
                        ld_waiters[ld_tail] = 2'b01 << tid;
                        ld_tail = (ld_tail + 1) % DEPTH;
                        ld_count++;
                        r.status = ST_NEWLOAD;
                    end
                end
            end
        end else if (wb_count > dispatch_level || ld_count == 0) begin
            if (wb_count > 0) begin
                r.blk = wb_blocks[wb_head];
                wb_head = (wb_head + 1) % DEPTH;
                wb_count--;
                r.status = ST_WROTE;
            end
        end else begin
            blk = ld_blocks[ld_head];
            set = blk[5:0];
            r.wake = ld_waiters[ld_head];
            ld_head = (ld_head + 1) % DEPTH;
            ld_count--;
            line_valid[set] = 1'b1;
            line_dirty[set] = 1'b0;
            line_tag[set] = blk[26:6];
            r.blk = blk;
            r.status = ST_LOADED;
        end
        r.wcount = 4'(wb_count);
        r.lcount = 4'(ld_count);
        return r;
    endfunction

    function automatic void report(string field, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field,
                     exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_outstanding = 0;
        o_items = 0;
        o_status_seen = '0;
    end

    always @(posedge i_clk) begin
        t_miss_result e;
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                line_valid[s] = 1'b0;
                line_dirty[s] = 1'b0;
            end
            wb_head = 0; wb_tail = 0; wb_count = 0;
            ld_head = 0; ld_tail = 0; ld_count = 0;
            dispatch_level = 4'd6;
        end else begin
            if (i_cfg_valid && i_cfg_ready) dispatch_level = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(process_request(i_command, i_address,
                                                            i_is_write, i_thread_id));
                o_items++;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0d", $realtime,
                             i_status);
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    o_status_seen[e.status] = 1'b1;
                    report("status", e.status, i_status);
                    report("victim_flushed", e.flushed, i_victim_flushed);
                    report("wake_mask", e.wake, i_wake_mask);
                    report("memory_block", e.blk, i_memory_block);
                    report("write_count", e.wcount, i_write_count);
                    report("load_count", e.lcount, i_load_count);
                end
            end
        end
        o_outstanding = expected_results.size();
    end
endmodule

[tb/tb_nonblocking_cache_miss_controller.sv]
// Testbench top for the miss controller: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_nonblocking_cache_miss_controller;
    import nbcmc_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_command = 1'b0;
    logic [31:0] i_address = '0;
    logic        i_is_write = 1'b0;
    logic        i_thread_id = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic        o_victim_flushed;
    logic [1:0]  o_wake_mask;
    logic [26:0] o_memory_block;
    logic [3:0]  o_write_count;
    logic [3:0]  o_load_count;

    int         fail_count, outstanding, items;
    logic [7:0] status_seen;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         dispatch_pct = 25;
    logic       holding = 1'b0;
    int         quiet_cycles = 0;
    event       hold_trigger;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    nonblocking_cache_miss_controller i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_command(i_command),
        .i_address(i_address), .i_is_write(i_is_write), .i_thread_id(i_thread_id),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_victim_flushed(o_victim_flushed), .o_wake_mask(o_wake_mask),
        .o_memory_block(o_memory_block), .o_write_count(o_write_count),
        .o_load_count(o_load_count)
    );

    nbcmc_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_command(i_command),
        .i_address(i_address), .i_is_write(i_is_write), .i_thread_id(i_thread_id),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_status(o_status),
        .i_victim_flushed(o_victim_flushed), .i_wake_mask(o_wake_mask),
        .i_memory_block(o_memory_block), .i_write_count(o_write_count),
        .i_load_count(o_load_count),
        .o_fail_count(fail_count), .o_outstanding(outstanding), .o_items(items),
        .o_status_seen(status_seen)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || holding) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        forever begin
            @(hold_trigger);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(logic cmd, logic [31:0] addr, logic wr, logic tid);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_address <= addr;
        i_is_write <= wr;
        i_thread_id <= tid;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic program_threshold(logic [3:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly a small pool of tags and sets so that hits, merges and evictions recur
    function automatic logic [31:0] pick_address();
        logic [20:0] tag;
        logic [5:0]  set;
        if ($urandom_range(0, 99) < 12) return $urandom;
        case ($urandom_range(0, 3))
            0: tag = '0;
            1: tag = 21'd1;
            2: tag = 21'd2;
            default: tag = '1;
        endcase
        case ($urandom_range(0, 3))
            0: set = '0;
            1: set = 6'd1;
            2: set = 6'd2;
            default: set = '1;
        endcase
        return {tag, set, 5'($urandom)};
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < dispatch_pct)
                send_request(1'b1, $urandom, 1'($urandom), 1'($urandom));
            else
                send_request(1'b0, pick_address(), 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle dispatch, new load, merge, fill, hits, eviction, write-buffer fill
        send_request(1'b1, 32'h0, 1'b0, 1'b0);
        send_request(1'b0, 32'h0000_0000, 1'b0, 1'b0);
        send_request(1'b0, 32'h0000_001F, 1'b1, 1'b1);
        send_request(1'b1, 32'h0, 1'b0, 1'b0);
        send_request(1'b0, 32'h0000_0004, 1'b0, 1'b1);
        send_request(1'b0, 32'h0000_0008, 1'b1, 1'b0);
        send_request(1'b0, 32'h0000_0800, 1'b0, 1'b0);
        send_request(1'b0, 32'h0000_0000, 1'b0, 1'b1);
        send_request(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        for (int n = 0; n < 9; n++) send_request(1'b0, {21'd5 + 21'(n), 11'h7E0}, 1'b0, 1'b0);
        for (int n = 0; n < 6; n++) send_request(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);

        program_threshold(4'd0);
        random_phase(120);
        program_threshold(4'd8);
        dispatch_pct = 12;
        random_phase(150);
        ->hold_trigger;
        random_phase(30);
        drain_results();
        program_threshold(4'd7);
        dispatch_pct = 30;
        send_idle_pct = 72;
        random_phase(130);
        program_threshold(4'd3);
        send_idle_pct = 0;
        recv_stall_pct = 72;
        random_phase(130);
        program_threshold(4'd6);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        random_phase(130);
        program_threshold(4'd15);
        dispatch_pct = 20;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(120);

        drain_results();
        repeat (30) @(posedge i_clk);
        $display("covered %0d items over thresholds 0, 3, 6, 7, 8, 15 and four stall mixes",
                 items);
        $display("result kinds seen (bit per status): %08b", status_seen);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

[nonblocking_cache_miss_controller.f]
hdl/nbcmc_pkg.sv
hdl/nbcmc_scan.sv
hdl/nonblocking_cache_miss_controller.sv
tb/nbcmc_scoreboard.sv
tb/tb_nonblocking_cache_miss_controller.sv
